@@ rtl/core/lfsr_scr_pkg.sv @@
// Shared types and constants of the additive LFSR byte scrambler.
// No dependencies; used by every module under rtl/core.
package lfsr_scr_pkg;

  // Default shift register width
  localparam int unsigned REG_WIDTH_DEF = 32;
  // Fixed widths of the configuration fields
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned TAP_W   = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned BITS_W  = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  // Key bits per byte are capped at one byte
  localparam int unsigned MAX_STEPS = 8;
  // Entries of the front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED  = 3'd0,
    CFG_TAP   = 3'd1,
    CFG_LEN   = 3'd2,
    CFG_BITS  = 3'd3,
    CFG_ORDER = 3'd4
  } cfg_idx_e;

  // One classified input beat as it sits in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
  } item_t;

  // Resolved controls from the register file to the back end
  typedef struct packed {
    logic [SEED_W-1:0] seed;
    logic [TAP_W-1:0]  tap;
    logic [LEN_W-1:0]  fb_pos;    // clamped feedback bit position
    logic [BITS_W-1:0] steps;     // clamped key bits per byte
    logic              lsb_first;
  } ctl_t;

endpackage

@@ rtl/core/lfsr_scr_cfg.sv @@
// Configuration register file; resolves lengths into clamped controls.
// Depends on lfsr_scr_pkg.
module lfsr_scr_cfg #(
  parameter int unsigned REG_WIDTH = lfsr_scr_pkg::REG_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [lfsr_scr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lfsr_scr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output lfsr_scr_pkg::ctl_t                    ctl_o
);

  logic [lfsr_scr_pkg::SEED_W-1:0] seed_q;
  logic [lfsr_scr_pkg::TAP_W-1:0]  tap_q;
  logic [lfsr_scr_pkg::LEN_W-1:0]  len_q;
  logic [lfsr_scr_pkg::BITS_W-1:0] bits_q;
  logic                            order_q;
  logic                            wr;

  assign cfg_ready_o = 1'b1;
  assign wr = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= lfsr_scr_pkg::SEED_W'(1);
      tap_q   <= '0;
      len_q   <= lfsr_scr_pkg::LEN_W'(32);
      bits_q  <= lfsr_scr_pkg::BITS_W'(lfsr_scr_pkg::MAX_STEPS);
      order_q <= 1'b0;
    end else if (wr) begin
      case (lfsr_scr_pkg::cfg_idx_e'(cfg_index_i))
        lfsr_scr_pkg::CFG_SEED:  seed_q  <= cfg_data_i[lfsr_scr_pkg::SEED_W-1:0];
        lfsr_scr_pkg::CFG_TAP:   tap_q   <= cfg_data_i[lfsr_scr_pkg::TAP_W-1:0];
        lfsr_scr_pkg::CFG_LEN:   len_q   <= cfg_data_i[lfsr_scr_pkg::LEN_W-1:0];
        lfsr_scr_pkg::CFG_BITS:  bits_q  <= cfg_data_i[lfsr_scr_pkg::BITS_W-1:0];
        lfsr_scr_pkg::CFG_ORDER: order_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Length zero acts as one; lengths past the register saturate.
  always_comb begin
    ctl_o.seed      = seed_q;
    ctl_o.tap       = tap_q;
    ctl_o.lsb_first = order_q;
    if (len_q == '0) begin
      ctl_o.fb_pos = '0;
    end else if ({1'b0, len_q} > 7'(REG_WIDTH)) begin
      ctl_o.fb_pos = lfsr_scr_pkg::LEN_W'(REG_WIDTH - 1);
    end else begin
      ctl_o.fb_pos = len_q - lfsr_scr_pkg::LEN_W'(1);
    end
    if (bits_q > lfsr_scr_pkg::BITS_W'(lfsr_scr_pkg::MAX_STEPS)) begin
      ctl_o.steps = lfsr_scr_pkg::BITS_W'(lfsr_scr_pkg::MAX_STEPS);
    end else begin
      ctl_o.steps = bits_q;
    end
  end

  a_fb_pos_in_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    7'(ctl_o.fb_pos) < 7'(REG_WIDTH))
    else $error("feedback position outside register");

  a_steps_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.steps <= lfsr_scr_pkg::BITS_W'(lfsr_scr_pkg::MAX_STEPS))
    else $error("key bit count above one byte");

endmodule

@@ rtl/core/lfsr_scr_front.sv @@
// Front end: takes input beats, tags them, and queues them for the back end.
// Depends on lfsr_scr_pkg.
module lfsr_scr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_in_i,
  input  logic                packet_start_i,
  input  logic                packet_end_i,
  output logic                head_valid_o,
  output lfsr_scr_pkg::item_t head_o,
  input  logic                pop_i
);

  localparam int unsigned Depth = lfsr_scr_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  lfsr_scr_pkg::item_t q_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  lfsr_scr_pkg::item_t item;

  assign in_stall_o   = (count_q == CntW'(Depth));
  assign push         = in_valid_i & ~in_stall_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = q_q[rd_ptr_q];

  assign item.data  = data_in_i;
  assign item.start = packet_start_i;
  assign item.last  = packet_end_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({push, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue over capacity");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");

endmodule

@@ rtl/core/lfsr_scr_back.sv @@
// Back end: runs the shift register for one byte per beat, output register.
// Depends on lfsr_scr_pkg.
module lfsr_scr_back #(
  parameter int unsigned REG_WIDTH = lfsr_scr_pkg::REG_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfsr_scr_pkg::ctl_t  ctl_i,
  input  logic                head_valid_i,
  input  lfsr_scr_pkg::item_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          data_out_o,
  output logic                last_out_o
);

  localparam int unsigned ExtW = (REG_WIDTH > 32) ? REG_WIDTH : 32;

  logic [REG_WIDTH-1:0] lfsr_q;
  logic [REG_WIDTH-1:0] seed_w, tap_w, fb_hot, st;
  logic [ExtW-1:0]      seed_x, tap_x;
  logic [7:0]           key;
  logic [2:0]           pos;
  logic                 fb;
  logic                 out_valid_q, last_q;
  logic [7:0]           data_q;

  assign seed_x = ExtW'(ctl_i.seed);
  assign tap_x  = ExtW'(ctl_i.tap);
  assign seed_w = seed_x[REG_WIDTH-1:0];
  assign tap_w  = tap_x[REG_WIDTH-1:0];
  assign fb_hot = REG_WIDTH'(1) << ctl_i.fb_pos;

  // Free the output register or hand it on in the same cycle
  assign pop_o = head_valid_i & (~out_valid_q | ~out_stall_i);

  // Up to eight steps per byte; feedback ORs into the shifted word
  always_comb begin
    st  = head_i.start ? seed_w : lfsr_q;
    key = '0;
    pos = '0;
    fb  = 1'b0;
    for (int k = 0; k < lfsr_scr_pkg::MAX_STEPS; k++) begin
      if (lfsr_scr_pkg::BITS_W'(k) < ctl_i.steps) begin
        pos = ctl_i.lsb_first ? 3'(k)
                              : 3'(ctl_i.steps - lfsr_scr_pkg::BITS_W'(k) - 4'd1);
        key[pos] = st[0];
        fb = ^(st & tap_w);
        st = (st >> 1) | (fb_hot & {REG_WIDTH{fb}});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q      <= REG_WIDTH'(1);
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      lfsr_q      <= st;
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i.data ^ key;
      last_q <= head_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_q;
  assign last_out_o  = last_q;

  a_pop_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped beat not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o)
    else $error("stalled result overwritten");

endmodule

@@ rtl/core/additive_lfsr_byte_scrambler_top.sv @@
// Top level of the additive LFSR byte scrambler / descrambler.
// Depends on lfsr_scr_pkg, lfsr_scr_cfg, lfsr_scr_front, lfsr_scr_back.
//
// Each data byte is XORed with a key byte drawn from a shift register that
// is reloaded from seed_value on any beat carrying packet_start. Every key
// bit is register bit 0; the register then shifts right and the parity of
// (register & tap_mask) is ORed in at bit register_length-1 (0 acts as 1,
// values past REG_WIDTH saturate). The configured number of key bits per
// byte (capped at 8) is packed from bit (count-1) down, or from bit 0 up when
// bit_order is 1; key bits above that count are zero. packet_end is returned
// as last_out. The block takes one byte per clock cycle while the output
// does not stall; each byte passes through a queue entry and then the output
// register. The back end runs all key steps of a byte combinationally.
// A two-entry queue separates the input side from the back end, and a single
// output register holds a result while the downstream stalls. Configuration
// applies to beats that leave the queue after the write, so write it only
// while no beat is in flight; seed changes touch only the next packet start.
// There is no clearing pass after reset.
module additive_lfsr_byte_scrambler_top #(
  parameter int unsigned REG_WIDTH = lfsr_scr_pkg::REG_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lfsr_scr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lfsr_scr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input byte beats
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          data_in_i,
  input  logic                                packet_start_i,
  input  logic                                packet_end_i,
  // output byte beats
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          data_out_o,
  output logic                                last_out_o
);

  lfsr_scr_pkg::ctl_t  ctl;
  lfsr_scr_pkg::item_t head;
  logic                head_valid;
  logic                pop;

  // register file and clamping of length / key bit count
  lfsr_scr_cfg #(
    .REG_WIDTH (REG_WIDTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_o       (ctl)
  );

  // input side: beat accept and queue
  lfsr_scr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_in_i      (data_in_i),
    .packet_start_i (packet_start_i),
    .packet_end_i   (packet_end_i),
    .head_valid_o   (head_valid),
    .head_o         (head),
    .pop_i          (pop)
  );

  // shift register, key build, XOR and output register
  lfsr_scr_back #(
    .REG_WIDTH (REG_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_out_o   (data_out_o),
    .last_out_o   (last_out_o)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for the additive LFSR byte scrambler top level.
// Needs lfsr_scr_pkg and additive_lfsr_byte_scrambler_top; nothing else.
// A bit-level predictor checks every output beat in order.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned REG_W = lfsr_scr_pkg::REG_WIDTH_DEF;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES = 600;
  localparam int unsigned MAX_REPORTS = 10;

  // What the block should emit for one byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [lfsr_scr_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [lfsr_scr_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_in_i = '0;
  logic       packet_start_i = 1'b0;
  logic       packet_end_i = 1'b0;

  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] data_out_o;
  logic       last_out_o;

  additive_lfsr_byte_scrambler_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_in_i      (data_in_i),
    .packet_start_i (packet_start_i),
    .packet_end_i   (packet_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_out_o     (data_out_o),
    .last_out_o     (last_out_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: register file and running shift register,
  // at their reset values.
  // ---------------------------------------------------------------------------
  logic [lfsr_scr_pkg::SEED_W-1:0] seed_r  = 32'd1;
  logic [lfsr_scr_pkg::TAP_W-1:0]  tap_r   = 32'd0;
  logic [lfsr_scr_pkg::LEN_W-1:0]  len_r   = 6'd32;
  logic [lfsr_scr_pkg::BITS_W-1:0] bits_r  = 4'd8;
  logic                            order_r = 1'b0;
  logic [REG_W-1:0]                lfsr_q  = REG_W'(1);

  lfsr_scr_pkg::item_t byte_feed_q[$];   // bytes waiting to be driven
  out_beat_t           scrambled_q[$];   // scrambled bytes the block still owes us

  int unsigned bytes_queued = 0;
  int unsigned bytes_taken  = 0;
  int unsigned err_count    = 0;
  int unsigned stuck_cycles = 0;

  logic in_took  = 1'b0;   // input beat accepted at the last rising edge
  logic cfg_took = 1'b0;   // config write accepted at the last rising edge
  logic no_idle  = 1'b0;   // phase-wide switch: no gaps, no stalls

  // Run the key generator over one byte and advance the shift register.
  function automatic out_beat_t predict_beat(lfsr_scr_pkg::item_t it);
    out_beat_t   res;
    logic [7:0]  key;
    logic        fb;
    int unsigned n;
    int unsigned fb_pos;
    int unsigned pos;
    key = '0;
    if (it.start) lfsr_q = seed_r[REG_W-1:0];
    n = (bits_r > 8) ? 8 : bits_r;
    // length 0 acts as 1, anything past the register width saturates
    if (len_r == 0) fb_pos = 0;
    else if (len_r > REG_W) fb_pos = REG_W - 1;
    else fb_pos = len_r - 1;
    for (int unsigned k = 0; k < n; k++) begin
      pos = order_r ? k : (n - 1 - k);
      key[pos] = lfsr_q[0];
      fb = ^(lfsr_q & tap_r[REG_W-1:0]);
      // feedback is ORed over whatever shifted into that position
      lfsr_q = (lfsr_q >> 1) | (REG_W'(fb) << fb_pos);
    end
    res.data = it.data ^ key;
    res.last = it.last;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Rising edge: sample every handshake, update the shadow, check outputs.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    out_beat_t got;
    out_beat_t want;
    logic      any_beat;
    if (!rst_ni) begin
      in_took  <= 1'b0;
      cfg_took <= 1'b0;
    end else begin
      in_took  <= in_valid_i && !in_stall_o;
      cfg_took <= cfg_valid_i && cfg_ready_o;
      any_beat = 1'b0;

      if (cfg_valid_i && cfg_ready_o) begin
        any_beat = 1'b1;
        case (lfsr_scr_pkg::cfg_idx_e'(cfg_index_i))
          lfsr_scr_pkg::CFG_SEED:  seed_r  = cfg_data_i[lfsr_scr_pkg::SEED_W-1:0];
          lfsr_scr_pkg::CFG_TAP:   tap_r   = cfg_data_i[lfsr_scr_pkg::TAP_W-1:0];
          lfsr_scr_pkg::CFG_LEN:   len_r   = cfg_data_i[lfsr_scr_pkg::LEN_W-1:0];
          lfsr_scr_pkg::CFG_BITS:  bits_r  = cfg_data_i[lfsr_scr_pkg::BITS_W-1:0];
          lfsr_scr_pkg::CFG_ORDER: order_r = cfg_data_i[0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_o) begin
        any_beat = 1'b1;
        bytes_taken++;
        scrambled_q.push_back(predict_beat('{data: data_in_i, start: packet_start_i,
                                             last: packet_end_i}));
      end

      if (out_valid_o && !out_stall_i) begin
        any_beat = 1'b1;
        got.data = data_out_o;
        got.last = last_out_o;
        if (scrambled_q.size() == 0) begin
          if (err_count < MAX_REPORTS)
            $display("tb: unexpected output beat at %0t: data %02h last %0b",
                     $time, got.data, got.last);
          err_count++;
        end else begin
          want = scrambled_q.pop_front();
          if (got !== want) begin
            if (err_count < MAX_REPORTS)
              $display({"tb: mismatch at %0t: expected data %02h last %0b, ",
                        "got data %02h last %0b"},
                       $time, want.data, want.last, got.data, got.last);
            err_count++;
          end
        end
      end

      // watchdog: only quiet cycles count
      if (any_beat) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Falling edge: input driver. Holds a beat until it is taken, then
  // optionally idles before presenting the next one.
  // ---------------------------------------------------------------------------
  int unsigned feed_gap = 0;

  always @(negedge clk_i) begin : driver
    lfsr_scr_pkg::item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_took) begin
      // stalled: payload stays put
    end else if (feed_gap != 0) begin
      in_valid_i <= 1'b0;
      feed_gap--;
    end else if (byte_feed_q.size() != 0) begin
      it = byte_feed_q.pop_front();
      in_valid_i     <= 1'b1;
      data_in_i      <= it.data;
      packet_start_i <= it.start;
      packet_end_i   <= it.last;
      feed_gap = pick_gap();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver back-pressure: stall runs of random length
  int unsigned stall_left = 0;

  always @(negedge clk_i) begin : sink
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_byte(logic [7:0] data, logic start, logic last);
    byte_feed_q.push_back('{data: data, start: start, last: last});
    bytes_queued++;
  endtask

  // Well-formed packet: start on the first byte, end on the last
  task automatic queue_packet(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      queue_byte(8'($urandom), i == 0, i == len - 1);
  endtask

  // Block until every queued byte went in and every result came out
  task automatic drain();
    @(negedge clk_i);
    while (bytes_taken != bytes_queued || scrambled_q.size() != 0)
      @(negedge clk_i);
  endtask

  // One register write; unused upper data bits carry junk
  task automatic write_reg(lfsr_scr_pkg::cfg_idx_e idx, logic [31:0] val);
    logic [31:0] junk;
    junk = $urandom;
    case (idx)
      lfsr_scr_pkg::CFG_LEN:   val = (junk & ~32'h3F) | (val & 32'h3F);
      lfsr_scr_pkg::CFG_BITS:  val = (junk & ~32'hF) | (val & 32'hF);
      lfsr_scr_pkg::CFG_ORDER: val = (junk & ~32'h1) | (val & 32'h1);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    while (!cfg_took) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_reg_value(lfsr_scr_pkg::cfg_idx_e idx);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (idx)
      lfsr_scr_pkg::CFG_SEED: begin
        if (r == 0) return 32'h0;
        if (r == 1) return 32'hFFFF_FFFF;
        if (r == 2) return 32'h1;
        return $urandom;
      end
      lfsr_scr_pkg::CFG_TAP: begin
        if (r == 0) return 32'h0;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
      end
      lfsr_scr_pkg::CFG_LEN: begin
        if (r == 0) return 32'd0;
        if (r == 1) return $urandom_range(33, 63);
        if (r == 2) return 32'd1;
        if (r == 3) return 32'd32;
        return $urandom_range(1, 32);
      end
      lfsr_scr_pkg::CFG_BITS: begin
        if (r == 0) return 32'd0;
        if (r == 1) return $urandom_range(9, 15);
        return $urandom_range(1, 8);
      end
      default: return $urandom_range(0, 1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned             phase_bytes;
    int unsigned             target;
    int unsigned             len;
    lfsr_scr_pkg::cfg_idx_e  idx;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings, no packet start yet: register runs on from its reset value
    no_idle = 1'b0;
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b1);
    queue_byte(8'hA5, 1'b1, 1'b0);
    queue_byte(8'h5A, 1'b0, 1'b1);
    drain();

    // Touch every register once
    write_reg(lfsr_scr_pkg::CFG_SEED, 32'hFFFF_FFFF);
    write_reg(lfsr_scr_pkg::CFG_TAP, 32'h8020_0003);
    write_reg(lfsr_scr_pkg::CFG_LEN, 32'd32);
    write_reg(lfsr_scr_pkg::CFG_BITS, 32'd8);
    write_reg(lfsr_scr_pkg::CFG_ORDER, 32'd1);
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h3C, 1'b0, 1'b1);
    drain();

    // Seed rewritten mid-packet: running register must not notice
    queue_byte(8'h11, 1'b1, 1'b0);
    queue_byte(8'h22, 1'b0, 1'b0);
    drain();
    write_reg(lfsr_scr_pkg::CFG_SEED, 32'h1234_5678);
    queue_byte(8'h33, 1'b0, 1'b0);
    queue_byte(8'h44, 1'b0, 1'b1);
    queue_byte(8'h55, 1'b1, 1'b1);   // new seed applies here
    drain();

    // Length zero behaves as one
    write_reg(lfsr_scr_pkg::CFG_TAP, 32'hFFFF_FFFF);
    write_reg(lfsr_scr_pkg::CFG_LEN, 32'd0);
    queue_packet(2);
    drain();

    // Length past the register width saturates
    write_reg(lfsr_scr_pkg::CFG_LEN, 32'd63);
    queue_packet(2);
    drain();

    // Zero key bits: byte goes through untouched
    write_reg(lfsr_scr_pkg::CFG_BITS, 32'd0);
    queue_packet(2);
    drain();

    // Too many key bits saturate at eight, MSB-first packing
    write_reg(lfsr_scr_pkg::CFG_BITS, 32'd15);
    write_reg(lfsr_scr_pkg::CFG_ORDER, 32'd0);
    queue_packet(2);
    drain();

    // Single key bit, shortest register, zero seed
    write_reg(lfsr_scr_pkg::CFG_SEED, 32'h0);
    write_reg(lfsr_scr_pkg::CFG_LEN, 32'd1);
    write_reg(lfsr_scr_pkg::CFG_BITS, 32'd1);
    write_reg(lfsr_scr_pkg::CFG_ORDER, 32'd1);
    queue_packet(2);
    drain();

    // Random phases: each register rewritten or kept at random, mostly clean packets
    phase_bytes = 0;
    while (phase_bytes < RANDOM_BYTES) begin
      for (int i = 0; i <= lfsr_scr_pkg::CFG_ORDER; i++) begin
        idx = lfsr_scr_pkg::cfg_idx_e'(i);
        if ($urandom_range(0, 1) == 0) write_reg(idx, rand_reg_value(idx));
      end
      no_idle = ($urandom_range(0, 3) == 0);
      target = phase_bytes + $urandom_range(20, 70);
      while (phase_bytes < target) begin
        if ($urandom_range(0, 4) != 0) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                            : $urandom_range(1, 12);
          queue_packet(len);
          phase_bytes += len;
        end else begin
          // noise: arbitrary start/end marks
          len = $urandom_range(1, 4);
          for (int unsigned j = 0; j < len; j++)
            queue_byte(8'($urandom), $urandom_range(0, 3) == 0,
                       $urandom_range(0, 3) == 0);
          phase_bytes += len;
        end
      end
      drain();
    end

    // Let any stray beat show up before judging
    repeat (8) @(negedge clk_i);
    if (err_count == 0 && scrambled_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
